FILE: src/tty_opp_pkg.sv
// Package for the terminal output post-processor.
// Holds the item structs, the character codes, register indexes and sizing constants.
// Has no dependencies; every module of the block imports it.
package tty_opp_pkg;

   localparam int TAB_STOP = 8;
   localparam int COL_W = 16;
   localparam int PHASE_W = $clog2(TAB_STOP);
   localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};
   localparam logic [PHASE_W-1:0] COL_MAX_PHASE = PHASE_W'((2 ** COL_W - 1) % TAB_STOP);
   localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(TAB_STOP - 1);

   localparam int OMODE_W = 5;
   localparam int EMODE_W = 3;
   localparam int CSR_DATA_W = 5;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] REG_OUTPUT_MODE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_ECHO_MODE = 1'b1;
   localparam logic [OMODE_W-1:0] OUTPUT_MODE_RESET = 5'd19;
   localparam logic [EMODE_W-1:0] ECHO_MODE_RESET = 3'd1;

   localparam int OM_OPOST = 0;
   localparam int OM_ONLCR = 1;
   localparam int OM_OCRNL = 2;
   localparam int OM_ONOCR = 3;
   localparam int OM_ONLRET = 4;
   localparam int EM_ECHO = 0;
   localparam int EM_ECHONL = 1;
   localparam int EM_EXTPROC = 2;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_ECHO = 1'b1;

   localparam logic [7:0] CH_BS = 8'h08;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_NL = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DEL = 8'h7F;

   localparam int QUEUE_DEPTH = 3;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic       op;
      logic [7:0] char_code;
   } req_item_type;

   typedef struct packed {
      logic [7:0]       out_char;
      logic             last_of_item;
      logic [COL_W-1:0] column_now;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]         count;
      rsp_item_type       first;
      rsp_item_type       second;
      logic               update;
      logic [COL_W-1:0]   col_next;
      logic [PHASE_W-1:0] phase_next;
   } xlate_out_type;

endpackage

FILE: src/tty_opp_xlate.sv
// Per-item translation logic of the terminal output post-processor.
// Applies echo gating and the newline and carriage-return mappings and works out the new column.
// Depends on tty_opp_pkg.
module tty_opp_xlate (
   input  tty_opp_pkg::req_item_type                item,
   input  logic [tty_opp_pkg::OMODE_W-1:0]          output_mode,
   input  logic [tty_opp_pkg::EMODE_W-1:0]          echo_mode,
   input  logic [tty_opp_pkg::COL_W-1:0]            col,
   input  logic [tty_opp_pkg::PHASE_W-1:0]          phase,
   output tty_opp_pkg::xlate_out_type               result
);
   import tty_opp_pkg::*;

   logic                pass;
   logic                newline_expand;
   logic                cr_drop;
   logic [7:0]          eff_char;
   logic [COL_W:0]      tab_sum;
   logic [COL_W-1:0]    new_col;
   logic [PHASE_W-1:0]  new_phase;

   assign pass = (item.op == OP_WRITE) ||
                 ((echo_mode[EM_ECHO] || (echo_mode[EM_ECHONL] && item.char_code == CH_NL)) &&
                  !echo_mode[EM_EXTPROC]);

   assign newline_expand = (item.char_code == CH_NL) && output_mode[OM_ONLCR];
   assign cr_drop = (item.char_code == CH_CR) && !output_mode[OM_OCRNL] &&
                    output_mode[OM_ONOCR] && (col == '0);
   assign eff_char = ((item.char_code == CH_CR) && output_mode[OM_OCRNL]) ? CH_NL
                                                                           : item.char_code;

   assign tab_sum = {1'b0, col} + (COL_W + 1)'(TAB_STOP) - (COL_W + 1)'(phase);

   always_comb begin
      new_col = col;
      new_phase = phase;
      case (eff_char)
         CH_BS: begin
            if (col != '0) begin
               new_col = col - 1'b1;
               new_phase = (phase == '0) ? PHASE_LAST : phase - 1'b1;
            end
         end
         CH_NL: begin
            if (output_mode[OM_ONLCR] || output_mode[OM_ONLRET]) begin
               new_col = '0;
               new_phase = '0;
            end
         end
         CH_TAB: begin
            if (tab_sum > {1'b0, COL_MAX}) begin
               new_col = COL_MAX;
               new_phase = COL_MAX_PHASE;
            end else begin
               new_col = tab_sum[COL_W-1:0];
               new_phase = '0;
            end
         end
         CH_CR: begin
            new_col = '0;
            new_phase = '0;
         end
         default: begin
            if (eff_char >= CH_SPACE && eff_char != CH_DEL && col != COL_MAX) begin
               new_col = col + 1'b1;
               new_phase = (phase == PHASE_LAST) ? '0 : phase + 1'b1;
            end
         end
      endcase
   end

   always_comb begin
      result.count = 2'd0;
      result.first = '{out_char: item.char_code, last_of_item: 1'b1, column_now: col};
      result.second = '{out_char: CH_NL, last_of_item: 1'b1, column_now: new_col};
      result.update = 1'b0;
      result.col_next = new_col;
      result.phase_next = new_phase;
      if (pass) begin
         if (!output_mode[OM_OPOST]) begin
            result.count = 2'd1;
         end else if (newline_expand) begin
            result.count = 2'd2;
            result.first = '{out_char: CH_CR, last_of_item: 1'b0, column_now: col};
            result.update = 1'b1;
         end else if (!cr_drop) begin
            result.count = 2'd1;
            result.first = '{out_char: eff_char, last_of_item: 1'b1, column_now: new_col};
            result.update = 1'b1;
         end
      end
   end

endmodule

FILE: src/tty_output_post_processor_unit.sv
// Top level of the terminal output post-processor.
// Holds the input register, the cursor column state, the mode registers and the result queue.
// Depends on tty_opp_pkg and tty_opp_xlate.
//
//   port group   direction   flow control         payload
//   req_         in          req_valid/req_stall  req_item (op, char_code)
//   rsp_         out         rsp_valid/rsp_stall  rsp_item (out_char, last_of_item, column_now)
//   csr_         in          csr_wr_en            csr_index, csr_wdata
//
// An item is translated in the cycle after it is accepted; one item can be taken every cycle
// while the queue has room. A newline expanded to two bytes occupies two slots of the three-entry
// result queue. Results leave one per cycle from a registered queue head while rsp_stall is low.
// Reset is synchronous: it clears the column and all valid state and presets the mode registers.
// The input side stalls only when the result queue has too little room for the item's bytes.
module tty_output_post_processor_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  tty_opp_pkg::req_item_type              req_item,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output tty_opp_pkg::rsp_item_type              rsp_item,
   input  logic                                   csr_wr_en,
   input  logic [tty_opp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tty_opp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tty_opp_pkg::*;

   logic                  s1_valid_ff;
   req_item_type          s1_item_ff;
   logic [COL_W-1:0]      col_ff;
   logic [PHASE_W-1:0]    phase_ff;
   logic [OMODE_W-1:0]    output_mode_ff;
   logic [EMODE_W-1:0]    echo_mode_ff;
   rsp_item_type          queue_ff [QUEUE_DEPTH];
   rsp_item_type          queue_in [QUEUE_DEPTH];
   logic [QCNT_W-1:0]     count_ff;
   logic [QCNT_W-1:0]     count_in;

   xlate_out_type         xl;
   logic [QCNT_W-1:0]     free_slots;
   logic                  s1_adv;
   logic                  pop;
   logic [QCNT_W-1:0]     push_n;
   logic [QCNT_W-1:0]     base;

   tty_opp_xlate u_xlate (
      .item        (s1_item_ff),
      .output_mode (output_mode_ff),
      .echo_mode   (echo_mode_ff),
      .col         (col_ff),
      .phase       (phase_ff),
      .result      (xl)
   );

   assign free_slots = QCNT_W'(QUEUE_DEPTH) - count_ff;
   assign s1_adv = s1_valid_ff && (QCNT_W'(xl.count) <= free_slots);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign rsp_valid = (count_ff != '0);
   assign rsp_item = queue_ff[0];
   assign pop = rsp_valid && !rsp_stall;
   assign push_n = s1_adv ? QCNT_W'(xl.count) : '0;
   assign base = count_ff - QCNT_W'(pop);
   assign count_in = base + push_n;

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (pop && i < QUEUE_DEPTH - 1) begin
            queue_in[i] = queue_ff[i + 1];
         end else begin
            queue_in[i] = queue_ff[i];
         end
         if (push_n != '0 && QCNT_W'(i) == base) begin
            queue_in[i] = xl.first;
         end
         if (push_n == QCNT_W'(2) && QCNT_W'(i) == base + 1'b1) begin
            queue_in[i] = xl.second;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         count_ff <= '0;
         col_ff <= '0;
         phase_ff <= '0;
         output_mode_ff <= OUTPUT_MODE_RESET;
         echo_mode_ff <= ECHO_MODE_RESET;
      end else begin
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
         count_ff <= count_in;
         if (s1_adv && xl.update) begin
            col_ff <= xl.col_next;
            phase_ff <= xl.phase_next;
         end
         if (csr_wr_en) begin
            case (csr_index)
               REG_OUTPUT_MODE: output_mode_ff <= csr_wdata[OMODE_W-1:0];
               REG_ECHO_MODE:   echo_mode_ff <= csr_wdata[EMODE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_item_ff <= req_item;
      end
      queue_ff <= queue_in;
   end

endmodule
